// File: rtl/servo_frame_decoder_unit_assert.svh
// assertion macros used by the checker file
`ifndef SERVO_FRAME_DECODER_UNIT_ASSERT_SVH
`define SERVO_FRAME_DECODER_UNIT_ASSERT_SVH

// condition in a cycle implies a consequence in the same cycle
`define SFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("servo frame decoder check failed");

// condition in a cycle implies a consequence in the next cycle
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("servo frame decoder check failed");

`endif

// File: rtl/sfd_pkg.sv
// shared types, constants and the channel function of the servo frame decoder
`timescale 1ns / 1ps
package sfd_pkg;

  // frame characters and positions
  localparam logic [7:0]  START_CHAR  = 8'h2A;
  localparam logic [7:0]  END_CHAR    = 8'h3F;
  localparam logic [3:0]  END_POS     = 4'd11;
  localparam logic [7:0]  LETTER_BASE = 8'h61;
  localparam logic [7:0]  DIGIT_BASE  = 8'h30;

  // pair bookkeeping
  localparam int          PAIR_COUNT  = 5;
  localparam int          PAIR_IDX_W  = $clog2(PAIR_COUNT);
  localparam logic [PAIR_IDX_W-1:0] PAIR_LAST = PAIR_IDX_W'(PAIR_COUNT - 1);

  // field widths
  localparam int          BYTE_W      = 8;
  localparam int          BASE_W      = 12;
  localparam int          STEP_W      = 6;
  localparam int          CHAN_W      = 3;
  localparam int          CMP_W       = 15;
  localparam int          POS_W       = 4;

  // configuration register indexes and reset values
  localparam logic CFG_PULSE_BASE = 1'b0;
  localparam logic CFG_PULSE_STEP = 1'b1;
  localparam logic [BASE_W-1:0] BASE_RESET = 12'd900;
  localparam logic [STEP_W-1:0] STEP_RESET = 6'd10;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic byte_take;   // input byte transfer
    logic pair_clr;    // frame complete, restart pair counter
    logic out_load;    // load next result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_done;  // incoming byte closes a frame
    logic pair_last;   // pair counter at the fifth pair
    logic out_full;    // output register holds a result
  } sts_t;

  // letter offset to pwm channel, zero for letters that name no motor
  function automatic logic [CHAN_W-1:0] chan_of(input logic [BYTE_W-1:0] sel);
    logic [CHAN_W-1:0] ch;
    case (sel)
      8'd0:    ch = 3'd1;
      8'd1:    ch = 3'd2;
      8'd2:    ch = 3'd4;
      8'd3:    ch = 3'd3;
      8'd4:    ch = 3'd3;
      default: ch = 3'd0;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/sfd_ctrl.sv
// controller state machine: byte intake and result sequencing
`timescale 1ns / 1ps
module sfd_ctrl
  import sfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_ready,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.frame_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if ((!sts.out_full || out_ready) && sts.pair_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.byte_take = 1'b0;
    cmd.pair_clr  = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.byte_take = in_valid;
        cmd.pair_clr  = in_valid && sts.frame_done;
      end
      ST_EMIT: begin
        cmd.out_load = !sts.out_full || out_ready;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/sfd_datapath.sv
// datapath: frame store, position, config registers, compare value and output register
`timescale 1ns / 1ps
module sfd_datapath
  import sfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [BASE_W-1:0] cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CHAN_W-1:0] out_channel,
  output logic              out_update_valid,
  output logic [CMP_W-1:0]  out_compare_value,
  output logic              out_last
);

  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [BYTE_W-1:0]     letter_r [PAIR_COUNT];
  logic [BYTE_W-1:0]     digit_r  [PAIR_COUNT];
  logic [PAIR_IDX_W-1:0] pair_r;
  logic [BASE_W-1:0]     base_r;
  logic [STEP_W-1:0]     step_r;
  logic                  out_valid_r;

  logic [POS_W-1:0]      pos_m1;
  logic                  in_frame;
  logic [PAIR_IDX_W-1:0] wr_pair;
  logic [BYTE_W-1:0]     cur_letter;
  logic [BYTE_W-1:0]     sel;
  logic [BYTE_W-1:0]     dig;
  logic                  hit;
  logic [CMP_W-1:0]      cmp;

  // frame byte slot of the current position
  assign pos_m1   = pos_r - POS_W'(1);
  assign in_frame = (pos_r != '0) && (pos_r < END_POS);
  assign wr_pair  = pos_m1[PAIR_IDX_W:1];

  assign sts.frame_done = (in_rx_byte == END_CHAR) && (pos_r == END_POS);
  assign sts.pair_last  = (pair_r == PAIR_LAST);
  assign sts.out_full   = out_valid_r;

  // position update
  always_comb begin
    if (in_rx_byte == START_CHAR) begin
      pos_nxt = POS_W'(1);
    end else if (sts.frame_done || pos_r >= END_POS) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.byte_take) begin
      pos_r <= pos_nxt;
    end
  end

  // frame store, letters at odd positions, digits at even ones
  always_ff @(posedge clk) begin
    if (cmd.byte_take && in_frame) begin
      if (!pos_m1[0]) begin
        letter_r[wr_pair] <= in_rx_byte;
      end else begin
        digit_r[wr_pair] <= in_rx_byte;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      step_r <= STEP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PULSE_BASE: base_r <= cfg_data;
        CFG_PULSE_STEP: step_r <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // pair counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r <= '0;
    end else if (cmd.pair_clr) begin
      pair_r <= '0;
    end else if (cmd.out_load) begin
      pair_r <= pair_r + PAIR_IDX_W'(1);
    end
  end

  // channel and compare value of the current pair
  assign cur_letter = letter_r[pair_r];
  assign sel        = cur_letter - LETTER_BASE;
  assign dig        = digit_r[pair_r] - DIGIT_BASE;
  assign hit        = (sel < BYTE_W'(PAIR_COUNT));
  assign cmp        = (CMP_W'(dig) * CMP_W'(step_r)) + CMP_W'(base_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel       <= hit ? chan_of(sel) : '0;
      out_update_valid  <= hit;
      out_compare_value <= hit ? cmp : '0;
      out_last          <= sts.pair_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/servo_frame_decoder_unit.sv
// Top level of the servo frame decoder.
// Throughput: one received byte per cycle while no frame is being emitted.
// A closing '?' leads to five results, loaded one per cycle into the output
// register whenever it is empty or being read; the first is loaded once the
// controller state register has entered its emit state, and a frame is 12 byte transfers.
// Reset clears position, pair counter and output valid, and sets config (base 900, step 10).
`timescale 1ns / 1ps
module servo_frame_decoder_unit
  import sfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAN_W-1:0] out_channel,
  output logic              out_update_valid,
  output logic [CMP_W-1:0]  out_compare_value,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [BASE_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  // controller
  sfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // datapath
  sfd_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_rx_byte        (in_rx_byte),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_channel       (out_channel),
    .out_update_valid  (out_update_valid),
    .out_compare_value (out_compare_value),
    .out_last          (out_last)
  );

endmodule

// File: rtl/sfd_checker.sv
// port level checks of the servo frame decoder, bound to the top level
`timescale 1ns / 1ps
`include "servo_frame_decoder_unit_assert.svh"
module sfd_checker
  import sfd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [BYTE_W-1:0] in_rx_byte,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAN_W-1:0] out_channel,
  input logic              out_update_valid,
  input logic [CMP_W-1:0]  out_compare_value,
  input logic              out_last,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic              cfg_index,
  input logic [BASE_W-1:0] cfg_data
);

  // stalled result holds
  `SFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_compare_value) && $stable(out_channel) && $stable(out_last))

  // no update means channel and compare value are zero
  `SFD_ASSERT_SAME(a_no_update_zero, clk, rst_n, out_valid && !out_update_valid, out_channel == '0 && out_compare_value == '0)

  // an update names a real channel and stays in range
  `SFD_ASSERT_SAME(a_update_range, clk, rst_n, out_valid && out_update_valid, out_channel != '0 && out_channel <= CHAN_W'(4) && out_compare_value <= CMP_W'(20160))

  // a frame opens with a result that is not last, so two last marks never follow
  `SFD_ASSERT_NEXT(a_last_gap, clk, rst_n, out_valid && out_ready && out_last, !(out_valid && out_last))

endmodule

bind servo_frame_decoder_unit sfd_checker u_sfd_checker (.*);

// File: tb/tb_servo_frame_decoder_unit.sv
// self-checking testbench: byte frames in, predicted pwm updates compared per transfer
`timescale 1ns / 1ps
module tb_servo_frame_decoder_unit;
  import sfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_HOLD     = 8;
  localparam int PHASE_BYTES    = 65;

  // one expected pwm update
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              update_valid;
    logic [CMP_W-1:0]  compare_value;
    logic              last;
  } servo_update_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [CHAN_W-1:0] out_channel;
  logic              out_update_valid;
  logic [CMP_W-1:0]  out_compare_value;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [BASE_W-1:0] cfg_data;

  servo_frame_decoder_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel       (out_channel),
    .out_update_valid  (out_update_valid),
    .out_compare_value (out_compare_value),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // decoder shadow state
  logic [BYTE_W-1:0] frame_store [1:10];
  logic [POS_W-1:0]  frame_pos;
  logic [BASE_W-1:0] base_shadow;
  logic [STEP_W-1:0] step_shadow;
  servo_update_t     pending_updates [$];

  // flow control and bookkeeping
  int send_idle_pct;
  int sink_stall_pct;
  int bytes_sent;
  int frames_done;
  int overruns;
  int updates_checked;
  int mismatches;
  int quiet_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // letter offset to motor channel
  function automatic logic [CHAN_W-1:0] motor_channel(input logic [BYTE_W-1:0] offset);
    logic [CHAN_W-1:0] ch;
    ch = '0;
    if (offset == 8'd0) ch = 3'd1;
    else if (offset == 8'd1) ch = 3'd2;
    else if (offset == 8'd2) ch = 3'd4;
    else if (offset == 8'd3 || offset == 8'd4) ch = 3'd3;
    return ch;
  endfunction

  // advance the shadow decoder by one received byte
  function automatic void decode_rx_byte(input logic [BYTE_W-1:0] b);
    servo_update_t     upd;
    logic [BYTE_W-1:0] offset;
    logic [BYTE_W-1:0] units;
    if (frame_pos >= 4'd1 && frame_pos <= 4'd10) frame_store[frame_pos] = b;
    if (b == START_CHAR) begin
      frame_pos = 4'd1;
    end else if (b == END_CHAR && frame_pos == END_POS) begin
      for (int k = 0; k < PAIR_COUNT; k++) begin
        offset = frame_store[2 * k + 1] - LETTER_BASE;
        units  = frame_store[2 * k + 2] - DIGIT_BASE;
        upd.channel       = motor_channel(offset);
        upd.update_valid  = (upd.channel != '0);
        upd.compare_value = upd.update_valid ?
          CMP_W'(units) * CMP_W'(step_shadow) + CMP_W'(base_shadow) : '0;
        upd.last          = (k == PAIR_COUNT - 1);
        pending_updates.push_back(upd);
      end
      frames_done++;
      frame_pos = '0;
    end else if (frame_pos >= END_POS) begin
      overruns++;
      frame_pos = '0;
    end else begin
      frame_pos = frame_pos + 4'd1;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    mismatches++;
  endtask

  // monitor: config and input transfers update the shadow, result transfers are checked
  always @(posedge clk) begin
    servo_update_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PULSE_BASE) base_shadow = cfg_data;
        else step_shadow = cfg_data[STEP_W-1:0];
      end
      if (in_valid && in_ready) decode_rx_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        if (pending_updates.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_updates.pop_front();
          updates_checked++;
          if (out_channel !== want.channel)
            report_mismatch("channel", int'(out_channel), int'(want.channel));
          if (out_update_valid !== want.update_valid)
            report_mismatch("update_valid", int'(out_update_valid), int'(want.update_valid));
          if (out_compare_value !== want.compare_value)
            report_mismatch("compare_value", int'(out_compare_value),
                            int'(want.compare_value));
          if (out_last !== want.last)
            report_mismatch("last", int'(out_last), int'(want.last));
        end
      end
      // watchdog on cycles without any transfer
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = 0;
    @(negedge clk);
    while (gap < 16 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // stop sending and let every pending update come out
  task automatic drain_updates();
    release_input();
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  task automatic settle_block();
    drain_updates();
    repeat (DRAIN_HOLD) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [BASE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_letter();
    if ($urandom_range(0, 99) < 85) return LETTER_BASE + BYTE_W'($urandom_range(0, 4));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_digit();
    if ($urandom_range(0, 99) < 85) return DIGIT_BASE + BYTE_W'($urandom_range(0, 9));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_random_frame();
    send_byte(START_CHAR);
    for (int k = 0; k < PAIR_COUNT; k++) begin
      send_byte(pick_letter());
      send_byte(pick_digit());
    end
    send_byte(END_CHAR);
  endtask

  // noise, overrun or truncated frame
  task automatic send_broken_sequence();
    logic [BYTE_W-1:0] closer;
    int                kind;
    kind = $urandom_range(0, 2);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      send_byte(START_CHAR);
      for (int k = 0; k < PAIR_COUNT; k++) begin
        send_byte(pick_letter());
        send_byte(pick_digit());
      end
      closer = BYTE_W'($urandom_range(0, 255));
      while (closer == END_CHAR || closer == START_CHAR) closer = BYTE_W'($urandom_range(0, 255));
      send_byte(closer);
    end else begin
      send_byte(START_CHAR);
      repeat ($urandom_range(1, 9)) send_byte(pick_digit());
    end
  endtask

  // mostly well-formed frames, with one pause for the sink to catch up
  task automatic run_random_traffic(input int nbytes);
    int  stop_at;
    bit  paused;
    stop_at = bytes_sent + nbytes;
    paused  = 1'b0;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 75) send_random_frame();
      else send_broken_sequence();
      if (!paused && bytes_sent >= stop_at - nbytes / 2) begin
        drain_updates();
        paused = 1'b1;
      end
    end
  endtask

  // reset config, all five letters but c, wrapped digits, stray '?' as a digit
  task automatic test_reset_config_frame();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    send_byte(START_CHAR);
    send_byte("a");
    send_byte(8'h00);
    send_byte("b");
    send_byte("9");
    send_byte("e");
    send_byte(8'hFF);
    send_byte("z");
    send_byte("5");
    send_byte("d");
    send_byte(END_CHAR);
    send_byte(END_CHAR);
    settle_block();
  endtask

  // largest base and step, start byte not '*', letters just outside the range
  task automatic test_extreme_config_frame();
    write_register(CFG_PULSE_BASE, 12'd4095);
    write_register(CFG_PULSE_STEP, 12'd63);
    send_byte(8'h55);
    send_byte("c");
    send_byte(8'h2F);
    send_byte(8'h60);
    send_byte("0");
    send_byte(8'h66);
    send_byte("1");
    send_byte("a");
    send_byte("2");
    send_byte("b");
    send_byte("3");
    send_byte(END_CHAR);
    settle_block();
  endtask

  task automatic test_random_slow_sink();
    write_register(CFG_PULSE_BASE, 12'd0);
    write_register(CFG_PULSE_STEP, 12'd0);
    send_idle_pct  = 32;
    sink_stall_pct = 85;
    run_random_traffic(PHASE_BYTES);
    settle_block();
  endtask

  task automatic test_random_slow_source();
    write_register(CFG_PULSE_BASE, BASE_W'($urandom_range(0, 4095)));
    write_register(CFG_PULSE_STEP, BASE_W'($urandom_range(0, 63)));
    send_idle_pct  = 85;
    sink_stall_pct = 32;
    run_random_traffic(PHASE_BYTES);
    settle_block();
  endtask

  task automatic test_random_full_rate();
    write_register(CFG_PULSE_BASE, 12'd4095);
    write_register(CFG_PULSE_STEP, BASE_W'($urandom_range(1, 62)));
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    run_random_traffic(PHASE_BYTES);
    settle_block();
  endtask

  // main sequence
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_rx_byte      = '0;
    out_ready       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_PULSE_BASE;
    cfg_data        = '0;
    frame_pos       = '0;
    base_shadow     = BASE_RESET;
    step_shadow     = STEP_RESET;
    send_idle_pct   = 0;
    sink_stall_pct  = 0;
    bytes_sent      = 0;
    frames_done     = 0;
    overruns        = 0;
    updates_checked = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    for (int i = 1; i <= 10; i++) frame_store[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_config_frame();
    test_extreme_config_frame();
    test_random_slow_sink();
    test_random_slow_source();
    test_random_full_rate();

    if (pending_updates.size() != 0)
      report_mismatch("updates never delivered", 0, pending_updates.size());
    $display("sent %0d bytes: %0d complete frames, %0d overruns, %0d updates checked",
             bytes_sent, frames_done, overruns, updates_checked);
    $display("five base/step settings under slow-sink, slow-source and full-rate flow");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_ctrl.sv
rtl/sfd_datapath.sv
rtl/servo_frame_decoder_unit.sv
rtl/sfd_checker.sv
tb/tb_servo_frame_decoder_unit.sv
